/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/ps2hsp_pkg.sv */
// ---------------------------------------------------------------------------
// PS/2 host serial port package
// Shared types and frame position constants.
// ---------------------------------------------------------------------------
package ps2hsp_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_INHIBIT = 2'd1,
    MODE_RX      = 2'd2,
    MODE_TX      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_RX_ENABLE = 2'd0,
    CMD_INHIBIT   = 2'd1,
    CMD_TX_REQ    = 2'd2,
    CMD_RELEASE   = 2'd3
  } cmd_e;

  localparam logic [3:0] PosStart      = 4'd0;
  localparam logic [3:0] PosLastData   = 4'd8;
  localparam logic [3:0] PosParityRx   = 4'd9;
  localparam logic [3:0] PosStop       = 4'd10;
  localparam logic [3:0] PosParityTx   = 4'd8;
  localparam logic [3:0] PosReleaseTx  = 4'd9;

  typedef struct packed {
    logic       req_type;
    logic       data_in;
    cmd_e       line_cmd;
    logic [7:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic       data_out;
    logic       clock_out;
    logic       rx_done;
    logic [7:0] rx_byte;
    logic       rx_error_flag;
    logic       tx_done;
    logic       tx_error_flag;
    mode_e      line_mode;
  } result_t;

endpackage

/* rtl/core/ps2hsp_engine.sv */
// ---------------------------------------------------------------------------
// PS/2 host serial port engine
// Line state and frame registers with the per-transfer update logic.
// ---------------------------------------------------------------------------
module ps2hsp_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ps2hsp_pkg::item_t   item_i,
  output ps2hsp_pkg::result_t res_o
);
  import ps2hsp_pkg::*;

  mode_e      mode_q, mode_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] shift_q, shift_d;
  logic       par_q, par_d;
  logic       rx_fault_q, rx_fault_d;
  logic       tx_fault_q, tx_fault_d;
  logic       data_drv_q, data_drv_d;
  logic       clk_drv_q, clk_drv_d;
  logic       rx_done, tx_done;

  always_comb begin
    mode_d = mode_q;
    if (item_i.req_type) begin
      unique case (item_i.line_cmd)
        CMD_RX_ENABLE: mode_d = MODE_RX;
        CMD_INHIBIT:   mode_d = MODE_INHIBIT;
        CMD_TX_REQ:    mode_d = MODE_TX;
        CMD_RELEASE:   mode_d = MODE_IDLE;
      endcase
    end else if (mode_q == MODE_TX && idx_q == PosStop) begin
      mode_d = MODE_RX;
    end
  end

  always_comb begin
    idx_d      = idx_q;
    shift_d    = shift_q;
    par_d      = par_q;
    rx_fault_d = rx_fault_q;
    tx_fault_d = tx_fault_q;
    data_drv_d = data_drv_q;
    clk_drv_d  = clk_drv_q;
    rx_done    = 1'b0;
    tx_done    = 1'b0;
    if (item_i.req_type) begin
      unique case (item_i.line_cmd)
        CMD_RX_ENABLE: begin
          data_drv_d = 1'b1;
          clk_drv_d  = 1'b1;
          idx_d      = PosStart;
        end
        CMD_INHIBIT: begin
          data_drv_d = 1'b1;
          clk_drv_d  = 1'b0;
        end
        CMD_TX_REQ: begin
          data_drv_d = 1'b0;
          clk_drv_d  = 1'b1;
          idx_d      = PosStart;
          par_d      = 1'b0;
          shift_d    = item_i.tx_byte;
        end
        CMD_RELEASE: begin
          data_drv_d = 1'b1;
          clk_drv_d  = 1'b1;
        end
      endcase
    end else if (mode_q == MODE_RX) begin
      if (idx_q == PosStart) begin
        if (!item_i.data_in) begin
          rx_fault_d = 1'b0;
          par_d      = 1'b0;
          idx_d      = idx_q + 4'd1;
        end
      end else if (idx_q <= PosLastData) begin
        shift_d = {item_i.data_in, shift_q[7:1]};
        par_d   = par_q ^ item_i.data_in;
        idx_d   = idx_q + 4'd1;
      end else if (idx_q == PosParityRx) begin
        if (!(par_q ^ item_i.data_in)) begin
          rx_fault_d = 1'b1;
        end
        idx_d = PosStop;
      end else if (idx_q == PosStop) begin
        if (!item_i.data_in) begin
          rx_fault_d = 1'b1;
        end
        idx_d   = PosStart;
        rx_done = 1'b1;
      end else begin
        idx_d = PosStart;
      end
    end else if (mode_q == MODE_TX) begin
      if (idx_q < PosParityTx) begin
        data_drv_d = shift_q[0];
        par_d      = par_q ^ shift_q[0];
        shift_d    = {1'b0, shift_q[7:1]};
        idx_d      = idx_q + 4'd1;
      end else if (idx_q == PosParityTx) begin
        data_drv_d = ~par_q;
        idx_d      = PosReleaseTx;
      end else if (idx_q == PosReleaseTx) begin
        data_drv_d = 1'b1;
        idx_d      = PosStop;
      end else if (idx_q == PosStop) begin
        tx_fault_d = item_i.data_in;
        idx_d      = PosStart;
        tx_done    = 1'b1;
      end else begin
        idx_d = PosStart;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      idx_q      <= PosStart;
      shift_q    <= 8'd0;
      par_q      <= 1'b0;
      rx_fault_q <= 1'b0;
      tx_fault_q <= 1'b0;
      data_drv_q <= 1'b1;
      clk_drv_q  <= 1'b1;
    end else if (en_i) begin
      mode_q     <= mode_d;
      idx_q      <= idx_d;
      shift_q    <= shift_d;
      par_q      <= par_d;
      rx_fault_q <= rx_fault_d;
      tx_fault_q <= tx_fault_d;
      data_drv_q <= data_drv_d;
      clk_drv_q  <= clk_drv_d;
    end
  end

  assign res_o = '{
    data_out:      data_drv_d,
    clock_out:     clk_drv_d,
    rx_done:       rx_done,
    rx_byte:       shift_d,
    rx_error_flag: rx_fault_d,
    tx_done:       tx_done,
    tx_error_flag: tx_fault_d,
    line_mode:     mode_d
  };

endmodule

/* rtl/core/ps2_host_serial_port.sv */
// A transfer accepted into the input stage passes through the engine into the result register.
// Throughput: one transfer per cycle while the output is not stalled; the line state update
// is a single pass through the engine logic between the input and result registers.
// Reset: asynchronous, active low; idle mode, both lines released, frame
// registers and error flags cleared, both pipeline stages empty.
// ---------------------------------------------------------------------------
// PS/2 host serial port
// Host side of one PS/2 link with an input stage and a result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2_host_serial_port (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic       data_in_i,
  input  logic [1:0] line_cmd_i,
  input  logic [7:0] tx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       data_out_o,
  output logic       clock_out_o,
  output logic       rx_done_o,
  output logic [7:0] rx_byte_o,
  output logic       rx_error_flag_o,
  output logic       tx_done_o,
  output logic       tx_error_flag_o,
  output logic [1:0] line_mode_o
);
  import ps2hsp_pkg::*;

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    in_accept;
  logic    advance;

  assign advance    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= '{
        req_type: req_type_i,
        data_in:  data_in_i,
        line_cmd: cmd_e'(line_cmd_i),
        tx_byte:  tx_byte_i
      };
    end
  end

  ps2hsp_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (s1_item_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_out_o      = res_q.data_out;
  assign clock_out_o     = res_q.clock_out;
  assign rx_done_o       = res_q.rx_done;
  assign rx_byte_o       = res_q.rx_byte;
  assign rx_error_flag_o = res_q.rx_error_flag;
  assign tx_done_o       = res_q.tx_done;
  assign tx_error_flag_o = res_q.tx_error_flag;
  assign line_mode_o     = res_q.line_mode;

  `ASSERT_ALWAYS(a_done_exclusive, !(out_valid_o && rx_done_o && tx_done_o))
  `ASSERT_ALWAYS(a_tx_done_to_rx, !(out_valid_o && tx_done_o) || (line_mode_o == MODE_RX))
  `ASSERT_ALWAYS(a_stall_needs_item, !in_stall_o || (s1_valid_q && out_valid_q))
  `ASSERT_NEXT(a_advance_fills_out, advance, out_valid_o)

endmodule
